>>> rtl/acmac_pkg.sv
package acmac_pkg;

    localparam int BlockBits = 128;
    localparam int CountBits = 5;
    localparam int RoundBits = 4;
    localparam logic [RoundBits-1:0] LastRound = 4'd10;
    localparam logic [7:0] DblConst = 8'h87;
    localparam logic [7:0] PadMark = 8'h80;
    localparam logic [CountBits-1:0] FullCount = 5'd16;

    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_TAG_MODE = 2'd2
    } cfg_index_t;

    // One classified item handed from the front part to the engine.
    typedef struct packed {
        logic [BlockBits-1:0] data;
        logic                 last;
        logic                 full;
        logic [3:0]           count;
    } work_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [BlockBits-1:0] s, input int i);
        return s[BlockBits-1-8*i -: 8];
    endfunction

    function automatic logic [BlockBits-1:0] dbl(input logic [BlockBits-1:0] v);
        return {v[BlockBits-2:0], 1'b0} ^ {120'd0, (v[BlockBits-1] ? DblConst : 8'h00)};
    endfunction

endpackage

>>> rtl/acmac_stream_if.sv
interface acmac_stream_if #(parameter int Width = 1);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/acmac_front.sv
// Classifies input blocks: applies padding on short last blocks and keeps
// a two-entry queue so the engine and the input side stall independently.
module acmac_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [63:0]              block_high,
    input  logic [63:0]              block_low,
    input  logic [4:0]               byte_count,
    input  logic                     last_block,
    input  logic                     in_valid,
    output logic                     in_ready,
    output acmac_pkg::work_t         work,
    output logic                     work_valid,
    input  logic                     work_take
);
    acmac_pkg::work_t q_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    acmac_pkg::work_t cls;
    logic [acmac_pkg::BlockBits-1:0] raw;
    logic             push;
    logic             pop;

    always_comb
    begin
        raw = {block_high, block_low};
        cls.last = last_block;
        cls.full = (byte_count >= acmac_pkg::FullCount);
        cls.count = byte_count[3:0];
        cls.data = raw;
        if (last_block && !cls.full)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (i > int'(byte_count))
                    cls.data[127-8*i -: 8] = 8'h00;
                else if (i == int'(byte_count))
                    cls.data[127-8*i -: 8] = acmac_pkg::PadMark;
            end
        end
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign pop = work_take && work_valid;
    assign work_valid = (fill_reg != 2'd0);
    assign work = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> rtl/acmac_round.sv
// One AES-128 round and one key-schedule step per cycle.
module acmac_round (
    input  logic [127:0] state,
    input  logic [127:0] round_key,
    input  logic [7:0]   rcon,
    input  logic         final_round,
    output logic [127:0] state_out,
    output logic [127:0] next_key
);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [31:0] w [4];
    logic [31:0] sw;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                sb[c*4+i] = acmac_pkg::SBOX[acmac_pkg::get_byte(state, ((c+i)%4)*4+i)];
        for (int c = 0; c < 4; c++)
        begin
            a0 = sb[c*4]; a1 = sb[c*4+1]; a2 = sb[c*4+2]; a3 = sb[c*4+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (final_round)
            begin
                t[c*4] = a0; t[c*4+1] = a1; t[c*4+2] = a2; t[c*4+3] = a3;
            end
            else
            begin
                t[c*4]   = a0 ^ all ^ acmac_pkg::xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ all ^ acmac_pkg::xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ all ^ acmac_pkg::xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ all ^ acmac_pkg::xtime(a3 ^ a0);
            end
        end
        for (int k = 0; k < 4; k++)
            w[k] = round_key[127-32*k -: 32];
        sw = {acmac_pkg::SBOX[w[3][23:16]] ^ rcon, acmac_pkg::SBOX[w[3][15:8]],
              acmac_pkg::SBOX[w[3][7:0]], acmac_pkg::SBOX[w[3][31:24]]};
        next_key[127:96] = w[0] ^ sw;
        next_key[95:64] = w[1] ^ next_key[127:96];
        next_key[63:32] = w[2] ^ next_key[95:64];
        next_key[31:0] = w[3] ^ next_key[63:32];
        for (int i = 0; i < 16; i++)
            state_out[127-8*i -: 8] = t[i] ^ next_key[127-8*i -: 8];
    end
endmodule

>>> rtl/acmac_engine.sv
// Runs subkey derivation when needed, applies the subkey, chains and
// iterates the round unit ten times per block.
module acmac_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [127:0]         key,
    input  logic                 key_written,
    input  logic                 tag_mode,
    input  acmac_pkg::work_t     work,
    input  logic                 work_valid,
    output logic                 work_take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [127:0]         out_tag
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t      state_reg;
    logic        derive_reg;
    logic        ready_reg;
    logic [3:0]  round_reg;
    logic [7:0]  rcon_reg;
    logic [127:0] s_reg;
    logic [127:0] rk_reg;
    logic [127:0] chain_reg;
    logic [127:0] k1_reg;
    logic [127:0] k2_reg;
    acmac_pkg::work_t job_reg;
    logic         tag_valid_reg;
    logic [127:0] tag_reg;
    logic [127:0] r_out;
    logic [127:0] r_key;

    acmac_round u_round (
        .state(s_reg), .round_key(rk_reg), .rcon(rcon_reg),
        .final_round(round_reg == acmac_pkg::LastRound),
        .state_out(r_out), .next_key(r_key)
    );

    assign work_take = (state_reg == ST_IDLE) && work_valid && !(tag_valid_reg && !out_ready);
    assign out_valid = tag_valid_reg;
    assign out_tag = tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            derive_reg <= 1'b0;
            ready_reg <= 1'b0;
            round_reg <= 4'd0;
            rcon_reg <= 8'h01;
            s_reg <= '0;
            rk_reg <= '0;
            chain_reg <= '0;
            k1_reg <= '0;
            k2_reg <= '0;
            job_reg <= '0;
            tag_valid_reg <= 1'b0;
            tag_reg <= '0;
        end
        else
        begin
            if (tag_valid_reg && out_ready)
                tag_valid_reg <= 1'b0;
            if (key_written)
                ready_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (work_take)
                    begin
                        job_reg <= work;
                        rk_reg <= key;
                        rcon_reg <= 8'h01;
                        round_reg <= 4'd1;
                        state_reg <= ST_RUN;
                        derive_reg <= !ready_reg;
                        s_reg <= ready_reg ? (work.last ? '0 : work.data ^ chain_reg) ^ key
                                           : key;
                    end
                end
                ST_RUN:
                begin
                    s_reg <= r_out;
                    rk_reg <= r_key;
                    rcon_reg <= acmac_pkg::xtime(rcon_reg);
                    round_reg <= round_reg + 4'd1;
                    if (round_reg == acmac_pkg::LastRound)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (derive_reg)
                    begin
                        // Subkeys are ready; restart the block encryption.
                        k1_reg <= acmac_pkg::dbl(s_reg);
                        k2_reg <= acmac_pkg::dbl(acmac_pkg::dbl(s_reg));
                        ready_reg <= 1'b1;
                        derive_reg <= 1'b0;
                        state_reg <= ST_RUN;
                        round_reg <= 4'd1;
                        rcon_reg <= 8'h01;
                        rk_reg <= key;
                        s_reg <= job_reg.data ^ chain_reg ^ key;
                        if (job_reg.last)
                            s_reg <= job_reg.data ^ (job_reg.full ? acmac_pkg::dbl(s_reg)
                                     : acmac_pkg::dbl(acmac_pkg::dbl(s_reg))) ^ chain_reg ^ key;
                    end
                    else if (!job_reg.last)
                    begin
                        chain_reg <= s_reg;
                        state_reg <= ST_IDLE;
                    end
                    else if (!tag_valid_reg || out_ready)
                    begin
                        chain_reg <= '0;
                        tag_valid_reg <= 1'b1;
                        tag_reg <= tag_mode ? {64'd0,
                            s_reg[119:112], s_reg[103:96], s_reg[87:80], s_reg[71:64],
                            s_reg[55:48], s_reg[39:32], s_reg[23:16], s_reg[7:0]} : s_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
            // A last block when subkeys are already valid enters with the subkey applied.
            if (state_reg == ST_IDLE && work_take && ready_reg && work.last)
                s_reg <= work.data ^ (work.full ? k1_reg : k2_reg) ^ chain_reg ^ key;
        end
    end
endmodule

>>> rtl/aes128_cmac_tag.sv
// AES-128 CMAC tag engine. Message blocks arrive on the input channel, one
// 128-bit block per transaction; the tag leaves on the output channel once
// for each last block. Each block takes a load step, ten round-unit steps
// and a finish step, and no new block is taken until the engine is idle;
// the first block after a key write runs subkey derivation first. A
// two-entry queue in front of the engine accepts blocks while the engine
// runs. Write the key and tag mode only while the block is idle.
module aes128_cmac_tag (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    acmac_stream_if.sink   in_ch,
    acmac_stream_if.source out_ch
);
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        tag_mode_reg;
    logic        key_written;
    acmac_pkg::work_t work;
    logic        work_valid;
    logic        work_take;

    assign key_written = cfg_we && (cfg_index == acmac_pkg::CFG_KEY_HIGH
                                    || cfg_index == acmac_pkg::CFG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            tag_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acmac_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                acmac_pkg::CFG_KEY_LOW:  key_low_reg <= cfg_data;
                acmac_pkg::CFG_TAG_MODE: tag_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    acmac_front u_front (
        .clk(clk), .rst_n(rst_n),
        .block_high(in_ch.data[133:70]), .block_low(in_ch.data[69:6]),
        .byte_count(in_ch.data[5:1]), .last_block(in_ch.data[0]),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .work(work), .work_valid(work_valid), .work_take(work_take)
    );

    acmac_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .key({key_high_reg, key_low_reg}), .key_written(key_written),
        .tag_mode(tag_mode_reg),
        .work(work), .work_valid(work_valid), .work_take(work_take),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_tag(out_ch.data)
    );
endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int InWidth = 2 * 64 + acmac_pkg::CountBits + 1;
    localparam logic [1:0] CfgSpare = 2'd3;
    localparam int SettleCycles = 40;
    localparam longint CycleLimit = 2000000;

    typedef struct {
        logic [63:0] tag_high;
        logic [63:0] tag_low;
    } tag_t;

    // Tracks the key, mode and CMAC chain, and holds the tags still owed by the block.
    class cmac_scoreboard;
        logic [127:0] key;
        logic         mode;
        logic [127:0] chain;
        logic [127:0] k1;
        logic [127:0] k2;
        bit           have_subkeys;
        tag_t         pending_tags[$];
        int           failures;

        function void clear();
            key = '0;
            mode = 1'b0;
            chain = '0;
            have_subkeys = 0;
            pending_tags.delete();
            failures = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [63:0] value);
            if (index == acmac_pkg::CFG_KEY_HIGH)
            begin
                key[127:64] = value;
                have_subkeys = 0;
            end
            else if (index == acmac_pkg::CFG_KEY_LOW)
            begin
                key[63:0] = value;
                have_subkeys = 0;
            end
            else if (index == acmac_pkg::CFG_TAG_MODE)
            begin
                mode = value[0];
            end
        endfunction

        function logic [7:0] mul2(logic [7:0] a);
            return (a << 1) ^ (a[7] ? 8'h1b : 8'h00);
        endfunction

        function logic [127:0] encrypt(logic [127:0] plain);
            logic [7:0] rk[176];
            logic [7:0] st[16];
            logic [7:0] t[16];
            logic [7:0] w[4];
            logic [7:0] rcon;
            logic [7:0] tmp;
            logic [7:0] mix;
            logic [127:0] res;
            rcon = 8'h01;
            for (int i = 0; i < 16; i++)
            begin
                rk[i] = key[127 - 8 * i -: 8];
                st[i] = plain[127 - 8 * i -: 8] ^ rk[i];
            end
            for (int i = 16; i < 176; i += 4)
            begin
                for (int j = 0; j < 4; j++)
                    w[j] = rk[i - 4 + j];
                if (i % 16 == 0)
                begin
                    tmp = w[0];
                    w[0] = acmac_pkg::SBOX[w[1]] ^ rcon;
                    w[1] = acmac_pkg::SBOX[w[2]];
                    w[2] = acmac_pkg::SBOX[w[3]];
                    w[3] = acmac_pkg::SBOX[tmp];
                    rcon = mul2(rcon);
                end
                for (int j = 0; j < 4; j++)
                    rk[i + j] = rk[i - 16 + j] ^ w[j];
            end
            for (int r = 1; r <= 10; r++)
            begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        t[c * 4 + i] = acmac_pkg::SBOX[st[((c + i) % 4) * 4 + i]];
                if (r != 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int j = 0; j < 4; j++)
                            w[j] = t[c * 4 + j];
                        mix = w[0] ^ w[1] ^ w[2] ^ w[3];
                        for (int j = 0; j < 4; j++)
                            t[c * 4 + j] = w[j] ^ mix ^ mul2(w[j] ^ w[(j + 1) % 4]);
                    end
                end
                for (int i = 0; i < 16; i++)
                    st[i] = t[i] ^ rk[r * 16 + i];
            end
            for (int i = 0; i < 16; i++)
                res[127 - 8 * i -: 8] = st[i];
            return res;
        endfunction

        function logic [127:0] gf_double(logic [127:0] v);
            return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
        endfunction

        function void note_block(logic [127:0] data, logic [4:0] count, logic last);
            logic [127:0] blk;
            logic [127:0] res;
            tag_t tag;
            if (!have_subkeys)
            begin
                k1 = gf_double(encrypt('0));
                k2 = gf_double(k1);
                have_subkeys = 1;
            end
            blk = data;
            if (last)
            begin
                if (count >= 16)
                begin
                    blk = blk ^ k1;
                end
                else
                begin
                    for (int i = 0; i < 16; i++)
                        if (i >= count)
                            blk[127 - 8 * i -: 8] = (i == count) ? acmac_pkg::PadMark : 8'h00;
                    blk = blk ^ k2;
                end
            end
            res = encrypt(blk ^ chain);
            if (!last)
            begin
                chain = res;
            end
            else
            begin
                chain = '0;
                if (mode)
                begin
                    tag.tag_high = '0;
                    for (int i = 0; i < 8; i++)
                        tag.tag_low[63 - 8 * i -: 8] = res[127 - 8 * (2 * i + 1) -: 8];
                end
                else
                begin
                    tag.tag_high = res[127:64];
                    tag.tag_low = res[63:0];
                end
                pending_tags.push_back(tag);
            end
        endfunction

        function void check_tag(logic [63:0] got_high, logic [63:0] got_low);
            tag_t want;
            if (pending_tags.size() == 0)
            begin
                $error("unexpected tag %h_%h", got_high, got_low);
                failures++;
                return;
            end
            want = pending_tags.pop_front();
            if (got_high !== want.tag_high)
            begin
                $error("tag_high: expected %h, actual %h", want.tag_high, got_high);
                failures++;
            end
            if (got_low !== want.tag_low)
            begin
                $error("tag_low: expected %h, actual %h", want.tag_low, got_low);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    acmac_stream_if #(.Width(InWidth)) in_ch ();
    acmac_stream_if #(.Width(128)) out_ch ();

    aes128_cmac_tag u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    cmac_scoreboard sb;
    int  send_idle_pct;
    int  tag_stall_pct;
    int  hold_off;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("** aes128_cmac_tag: FAILED **");
                $finish;
            end
        end
    end

    // Tag receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= tag_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_block(in_ch.data[InWidth-1 -: 128], in_ch.data[5:1], in_ch.data[0]);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_tag(out_ch.data[127:64], out_ch.data[63:0]);
    end

    task automatic write_reg(logic [1:0] index, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_key(logic [127:0] key, logic [63:0] mode);
        write_reg(acmac_pkg::CFG_KEY_HIGH, key[127:64]);
        write_reg(acmac_pkg::CFG_KEY_LOW, key[63:0]);
        write_reg(acmac_pkg::CFG_TAG_MODE, mode);
    endtask

    task automatic send_block(logic [127:0] data, logic [4:0] count, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {data, count, last};
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Waits until every owed tag has come out, then lets any trailing blocks finish.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (sb.pending_tags.size() > 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic send_message(int blocks, logic [4:0] count);
        for (int i = 1; i < blocks; i++)
            send_block(rand_block(), 5'($urandom_range(31)), 1'b0);
        send_block(rand_block(), count, 1'b1);
    endtask

    task automatic random_traffic(int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            len = $urandom_range(5, 1);
            if ($urandom_range(9) == 0)
                send_message(len, 5'($urandom_range(31)));
            else
                send_message(len, 5'($urandom_range(16)));
            sent += len;
        end
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        tag_stall_pct = 0;
        hold_off = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset key, empty message, full and short last blocks, saturated counts.
        send_block('0, 5'd0, 1'b1);
        send_block('1, 5'd16, 1'b1);
        send_block('1, 5'd17, 1'b1);
        send_block(rand_block(), 5'd31, 1'b1);
        send_block(rand_block(), 5'd1, 1'b1);
        send_block(rand_block(), 5'd15, 1'b1);
        send_block('1, 5'd0, 1'b0);
        send_block('1, 5'd8, 1'b1);
        quiesce();
        set_key(128'h2b7e151628aed2a6abf7158809cf4f3c, 64'hffff_ffff_ffff_fffe);
        send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16, 1'b1);
        send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd7, 1'b1);
        send_block(rand_block(), 5'd3, 1'b0);
        quiesce();
        // A key change in the middle of a message keeps the chain.
        write_reg(acmac_pkg::CFG_KEY_LOW, '1);
        write_reg(CfgSpare, '1);
        send_block(rand_block(), 5'd12, 1'b1);
        quiesce();
        set_key('1, 64'd1);
        send_block('0, 5'd16, 1'b1);
        send_block(rand_block(), 5'd9, 1'b0);
        send_block(rand_block(), 5'd2, 1'b1);
        quiesce();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 49 : (phase == 3) ? 37 : 0;
            tag_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 37 : 0;
            if (phase == 0)
                set_key('0, 64'd1);
            else
                set_key(rand_block(), 64'(phase % 2));
            if (phase == 0)
            begin
                // Stop taking tags long enough for the input side to back up.
                hold_off = 400;
                for (int i = 0; i < 8; i++)
                    send_block(rand_block(), 5'd5, 1'b1);
                quiesce();
            end
            random_traffic(480);
            quiesce();
        end

        if (sb.failures == 0 && sb.pending_tags.size() == 0)
            $display("** aes128_cmac_tag: PASSED **");
        else
            $display("** aes128_cmac_tag: FAILED **");
        $finish;
    end
endmodule
